>>> sv/hds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hds_pkg
// Shared widths, register indexes, pipeline stage map and types of the
// Helmert datum shift unit.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int FW  = 40;   // coordinate field width
  localparam int SHW = 32;   // shift register width
  localparam int RW  = 40;   // rotation register width
  localparam int SW  = 42;   // scale register width
  localparam int CW  = 44;   // internal coordinate width
  localparam int MW  = 44;   // multiplier operand width
  localparam int HW  = MW / 2;
  localparam int PW  = 2 * MW;
  localparam int AW  = PW + 2;
  localparam int OW  = CW + 1;

  localparam int ROT_FRAC = 44;
  localparam int SCL_FRAC = 40;

  localparam logic [SW-1:0] SCL_ONE = SW'(1) << SCL_FRAC;
  localparam logic signed [PW-1:0] SCL_HALF = PW'(1) << (SCL_FRAC - 1);
  localparam logic signed [AW-1:0] ROT_HALF = AW'(1) << (ROT_FRAC - 1);

  localparam int NUM_AXES = 3;
  localparam int NUM_PROD = 6;

  // configuration port
  localparam int CFG_IW = 4;
  localparam int CFG_DW = 42;
  localparam logic [CFG_IW-1:0] REG_SHIFT_X   = 4'd0;
  localparam logic [CFG_IW-1:0] REG_SHIFT_Y   = 4'd1;
  localparam logic [CFG_IW-1:0] REG_SHIFT_Z   = 4'd2;
  localparam logic [CFG_IW-1:0] REG_ROT_X     = 4'd3;
  localparam logic [CFG_IW-1:0] REG_ROT_Y     = 4'd4;
  localparam logic [CFG_IW-1:0] REG_ROT_Z     = 4'd5;
  localparam logic [CFG_IW-1:0] REG_SCALE     = 4'd6;
  localparam logic [CFG_IW-1:0] REG_INV_SCALE = 4'd7;

  // pipeline stage map
  localparam int ST_IN    = 0;
  localparam int ST_A_M1  = 1;
  localparam int ST_A_M2  = 2;
  localparam int ST_A_RND = 3;
  localparam int ST_R_M1  = 4;
  localparam int ST_R_M2  = 5;
  localparam int ST_R_CMB = 6;
  localparam int ST_B_M1  = 7;
  localparam int ST_B_M2  = 8;
  localparam int ST_B_RND = 9;
  localparam int ST_OUT   = 10;
  localparam int NUM_ST   = 11;

  typedef logic signed [FW-1:0] fld_t;
  typedef logic [NUM_AXES-1:0][CW-1:0] vec3_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } mul_en_t;

  typedef struct packed {
    mul_en_t mul;
    logic    rnd;
  } scale_en_t;

  typedef struct packed {
    mul_en_t mul;
    logic    cmb;
  } rot_en_t;

  typedef struct packed {
    logic op;
    logic nv;
    logic last;
    fld_t x;
    fld_t y;
    fld_t z;
  } side_t;

endpackage
`default_nettype wire

>>> sv/hds_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hds_in_if
// Point input channel: valid/ready handshake with one point per item.
// ----------------------------------------------------------------------------
interface hds_in_if;
  import hds_pkg::*;

  logic valid;
  logic ready;
  logic op;
  fld_t coord_x;
  fld_t coord_y;
  fld_t coord_z;
  logic no_value;
  logic last_point;

  modport source (output valid, op, coord_x, coord_y, coord_z, no_value, last_point,
                  input ready);
  modport sink   (input valid, op, coord_x, coord_y, coord_z, no_value, last_point,
                  output ready);
endinterface
`default_nettype wire

>>> sv/hds_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hds_out_if
// Result channel: valid/ready handshake with one transformed point per item.
// ----------------------------------------------------------------------------
interface hds_out_if;
  import hds_pkg::*;

  logic valid;
  logic ready;
  fld_t out_x;
  fld_t out_y;
  fld_t out_z;
  logic out_no_value;
  logic clipped;
  logic out_last_point;

  modport source (output valid, out_x, out_y, out_z, out_no_value, clipped, out_last_point,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_no_value, clipped, out_last_point,
                  output ready);
endinterface
`default_nettype wire

>>> sv/helmert_datum_shift_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// helmert_datum_shift_unit
// Seven-parameter small-angle Helmert shift of geocentric points. Path:
// shift subtract, scale, rotation, scale, shift add and saturation.
// Stages: input register, two scaling units and the rotation unit at 3
//   stages each, output register.
// Throughput: one item per clock; each stage advances when it or a later
//   stage holds a bubble, so a stalled output stops only what is behind it.
// Reset: clears all stage valid bits; shifts and rotations go to zero,
//   both scale registers to unity.
// ----------------------------------------------------------------------------
module helmert_datum_shift_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  hds_in_if.sink                     in_ch,
  hds_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [hds_pkg::CFG_IW-1:0] cfg_index,
  input  logic [hds_pkg::CFG_DW-1:0] cfg_wdata
);
  import hds_pkg::*;

  logic signed [SHW-1:0] shift_x_r, shift_y_r, shift_z_r;
  logic signed [RW-1:0]  rot_x_r, rot_y_r, rot_z_r;
  logic [SW-1:0]         scale_r, inv_scale_r;

  logic [NUM_ST-1:0]     vld_r;
  logic [NUM_ST-1:0]     en;
  side_t                 side_r [NUM_ST];
  side_t                 side_nxt;

  logic signed [SHW-1:0] shv [NUM_AXES];
  logic signed [CW-1:0]  sub [NUM_AXES];
  vec3_t                 pre_nxt, pre_r;
  vec3_t                 a_out, r_out, b_out;
  logic [SW-1:0]         coef_a, coef_b;
  scale_en_t             en_a, en_b;
  rot_en_t               en_r;

  logic signed [OW-1:0]  add [NUM_AXES];
  logic signed [OW-1:0]  sum [NUM_AXES];
  logic [NUM_AXES-1:0]   ovf;
  fld_t                  res_nxt [NUM_AXES];
  fld_t                  out_x_r, out_y_r, out_z_r;
  logic                  clipped_nxt, clipped_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_x_r   <= '0;
      shift_y_r   <= '0;
      shift_z_r   <= '0;
      rot_x_r     <= '0;
      rot_y_r     <= '0;
      rot_z_r     <= '0;
      scale_r     <= SCL_ONE;
      inv_scale_r <= SCL_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHIFT_X:   shift_x_r   <= cfg_wdata[SHW-1:0];
        REG_SHIFT_Y:   shift_y_r   <= cfg_wdata[SHW-1:0];
        REG_SHIFT_Z:   shift_z_r   <= cfg_wdata[SHW-1:0];
        REG_ROT_X:     rot_x_r     <= cfg_wdata[RW-1:0];
        REG_ROT_Y:     rot_y_r     <= cfg_wdata[RW-1:0];
        REG_ROT_Z:     rot_z_r     <= cfg_wdata[RW-1:0];
        REG_SCALE:     scale_r     <= cfg_wdata[SW-1:0];
        REG_INV_SCALE: inv_scale_r <= cfg_wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  assign shv[0] = shift_x_r;
  assign shv[1] = shift_y_r;
  assign shv[2] = shift_z_r;

  // stage k moves when it is empty or everything after it can move
  always_comb begin
    for (int k = 0; k < NUM_ST; k++) begin
      en[k] = out_ch.ready || ((vld_r >> k) != ({NUM_ST{1'b1}} >> k));
    end
  end

  assign in_ch.ready = en[ST_IN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[ST_IN]) begin
        vld_r[ST_IN] <= in_ch.valid;
      end
      for (int k = 1; k < NUM_ST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // input stage: inverse direction subtracts the shifts first
  always_comb begin
    side_nxt.op   = in_ch.op;
    side_nxt.nv   = in_ch.no_value;
    side_nxt.last = in_ch.last_point;
    side_nxt.x    = in_ch.coord_x;
    side_nxt.y    = in_ch.coord_y;
    side_nxt.z    = in_ch.coord_z;
    sub[0] = in_ch.op ? CW'(shift_x_r) : '0;
    sub[1] = in_ch.op ? CW'(shift_y_r) : '0;
    sub[2] = in_ch.op ? CW'(shift_z_r) : '0;
    pre_nxt[0] = CW'(in_ch.coord_x) - sub[0];
    pre_nxt[1] = CW'(in_ch.coord_y) - sub[1];
    pre_nxt[2] = CW'(in_ch.coord_z) - sub[2];
  end

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      side_r[ST_IN] <= side_nxt;
      pre_r         <= pre_nxt;
    end
    for (int k = 1; k < NUM_ST; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // first scaling: inverse scale, unity when going toward the reference
  assign coef_a      = side_r[ST_IN].op ? inv_scale_r : SCL_ONE;
  assign en_a.mul.s1 = en[ST_A_M1];
  assign en_a.mul.s2 = en[ST_A_M2];
  assign en_a.rnd    = en[ST_A_RND];

  hds_scale u_scale_a (
    .clk  (clk),
    .en   (en_a),
    .coef (coef_a),
    .vin  (pre_r),
    .vout (a_out)
  );

  assign en_r.mul.s1 = en[ST_R_M1];
  assign en_r.mul.s2 = en[ST_R_M2];
  assign en_r.cmb    = en[ST_R_CMB];

  hds_rot u_rot (
    .clk   (clk),
    .en    (en_r),
    .inv   (side_r[ST_R_M2].op),
    .rot_x (rot_x_r),
    .rot_y (rot_y_r),
    .rot_z (rot_z_r),
    .vin   (a_out),
    .vout  (r_out)
  );

  // second scaling: forward scale, unity when going away from the reference
  assign coef_b      = side_r[ST_R_CMB].op ? SCL_ONE : scale_r;
  assign en_b.mul.s1 = en[ST_B_M1];
  assign en_b.mul.s2 = en[ST_B_M2];
  assign en_b.rnd    = en[ST_B_RND];

  hds_scale u_scale_b (
    .clk  (clk),
    .en   (en_b),
    .coef (coef_b),
    .vin  (r_out),
    .vout (b_out)
  );

  // output stage: shift add, saturation, no-value bypass
  always_comb begin
    clipped_nxt = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      add[i] = side_r[ST_B_RND].op ? '0 : OW'(shv[i]);
      sum[i] = OW'($signed(b_out[i])) + add[i];
      ovf[i] = (sum[i][OW-1:FW-1] != {(OW-FW+1){1'b0}})
            && (sum[i][OW-1:FW-1] != {(OW-FW+1){1'b1}});
      if (ovf[i]) begin
        res_nxt[i] = sum[i][OW-1] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
      end else begin
        res_nxt[i] = sum[i][FW-1:0];
      end
    end
    if (side_r[ST_B_RND].nv) begin
      res_nxt[0] = side_r[ST_B_RND].x;
      res_nxt[1] = side_r[ST_B_RND].y;
      res_nxt[2] = side_r[ST_B_RND].z;
    end else begin
      clipped_nxt = |ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_x_r   <= res_nxt[0];
      out_y_r   <= res_nxt[1];
      out_z_r   <= res_nxt[2];
      clipped_r <= clipped_nxt;
    end
  end

  assign out_ch.valid          = vld_r[ST_OUT];
  assign out_ch.out_x          = out_x_r;
  assign out_ch.out_y          = out_y_r;
  assign out_ch.out_z          = out_z_r;
  assign out_ch.out_no_value   = side_r[ST_OUT].nv;
  assign out_ch.clipped        = clipped_r;
  assign out_ch.out_last_point = side_r[ST_OUT].last;
endmodule
`default_nettype wire

>>> sv/hds_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hds_mul
// Two-stage signed 44x44 multiplier: four 23x23 partial products, then sum.
// ----------------------------------------------------------------------------
module hds_mul (
  input  logic                      clk,
  input  hds_pkg::mul_en_t          en,
  input  logic signed [hds_pkg::MW-1:0] a,
  input  logic signed [hds_pkg::MW-1:0] b,
  output logic signed [hds_pkg::PW-1:0] p
);
  import hds_pkg::*;

  logic signed [HW:0]     a_hi, a_lo, b_hi, b_lo;
  logic signed [2*HW+1:0] hh_r, hl_r, lh_r, ll_r;
  logic signed [PW-1:0]   p_nxt, p_r;

  assign a_hi = {a[MW-1], a[MW-1:HW]};
  assign a_lo = {1'b0, a[HW-1:0]};
  assign b_hi = {b[MW-1], b[MW-1:HW]};
  assign b_lo = {1'b0, b[HW-1:0]};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      hh_r <= a_hi * b_hi;
      hl_r <= a_hi * b_lo;
      lh_r <= a_lo * b_hi;
      ll_r <= a_lo * b_lo;
    end
  end

  assign p_nxt = (PW'(hh_r) <<< (2 * HW)) + (PW'(hl_r) <<< HW)
               + (PW'(lh_r) <<< HW) + PW'(ll_r);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;
endmodule
`default_nettype wire

>>> sv/hds_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hds_scale
// Three-axis scaling by an unsigned 2^-40 factor, rounded to nearest
// (ties up). A factor of exactly one passes the point unchanged.
// ----------------------------------------------------------------------------
module hds_scale (
  input  logic                   clk,
  input  hds_pkg::scale_en_t     en,
  input  logic [hds_pkg::SW-1:0] coef,
  input  hds_pkg::vec3_t         vin,
  output hds_pkg::vec3_t         vout
);
  import hds_pkg::*;

  logic signed [PW-1:0] prod [NUM_AXES];
  logic signed [PW-1:0] acc  [NUM_AXES];
  vec3_t                vout_r;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    hds_mul u_mul (
      .clk (clk),
      .en  (en.mul),
      .a   (vin[i]),
      .b   (MW'(coef)),
      .p   (prod[i])
    );
    assign acc[i] = prod[i] + SCL_HALF;
  end

  always_ff @(posedge clk) begin
    if (en.rnd) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        vout_r[i] <= acc[i][SCL_FRAC+CW-1:SCL_FRAC];
      end
    end
  end

  assign vout = vout_r;
endmodule
`default_nettype wire

>>> sv/hds_rot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hds_rot
// Small-angle rotation rows. Six cross products run through split
// multipliers; the combine stage adds the coordinate term and rounds.
// inv selects the transposed matrix.
// ----------------------------------------------------------------------------
module hds_rot (
  input  logic                          clk,
  input  hds_pkg::rot_en_t              en,
  input  logic                          inv,
  input  logic signed [hds_pkg::RW-1:0] rot_x,
  input  logic signed [hds_pkg::RW-1:0] rot_y,
  input  logic signed [hds_pkg::RW-1:0] rot_z,
  input  hds_pkg::vec3_t                vin,
  output hds_pkg::vec3_t                vout
);
  import hds_pkg::*;

  logic signed [MW-1:0] rop  [NUM_PROD];
  logic signed [MW-1:0] cop  [NUM_PROD];
  logic signed [PW-1:0] prod [NUM_PROD];
  logic signed [AW-1:0] diff [NUM_AXES];
  logic signed [AW-1:0] acc  [NUM_AXES];
  vec3_t                a_d1_r, a_d2_r, vout_r;

  // x row: ry*z - rz*y, y row: rz*x - rx*z, z row: rx*y - ry*x
  assign rop[0] = MW'(rot_y);  assign cop[0] = $signed(vin[2]);
  assign rop[1] = MW'(rot_z);  assign cop[1] = $signed(vin[1]);
  assign rop[2] = MW'(rot_z);  assign cop[2] = $signed(vin[0]);
  assign rop[3] = MW'(rot_x);  assign cop[3] = $signed(vin[2]);
  assign rop[4] = MW'(rot_x);  assign cop[4] = $signed(vin[1]);
  assign rop[5] = MW'(rot_y);  assign cop[5] = $signed(vin[0]);

  for (genvar j = 0; j < NUM_PROD; j++) begin : g_prod
    hds_mul u_mul (
      .clk (clk),
      .en  (en.mul),
      .a   (rop[j]),
      .b   (cop[j]),
      .p   (prod[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en.mul.s1) begin
      a_d1_r <= vin;
    end
    if (en.mul.s2) begin
      a_d2_r <= a_d1_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      diff[i] = AW'(prod[2*i]) - AW'(prod[2*i+1]);
      acc[i]  = (AW'($signed(a_d2_r[i])) <<< ROT_FRAC)
              + (inv ? -diff[i] : diff[i]) + ROT_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en.cmb) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        vout_r[i] <= acc[i][ROT_FRAC+CW-1:ROT_FRAC];
      end
    end
  end

  assign vout = vout_r;
endmodule
`default_nettype wire

>>> sv/hds_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hds_checker
// Port-level checks of the datum shift unit, bound to the top level.
// ----------------------------------------------------------------------------
module hds_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [39:0]  out_x,
  input logic signed [39:0]  out_y,
  input logic signed [39:0]  out_z,
  input logic                out_no_value,
  input logic                clipped,
  input logic                out_last_point
);
  import hds_pkg::*;

  localparam fld_t SAT_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam fld_t SAT_MIN = {1'b1, {(FW-1){1'b0}}};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({out_x, out_y, out_z, out_no_value, clipped, out_last_point}))
    else $error("stalled result changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  a_nv_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_value |-> !clipped)
    else $error("no-value item flagged as clipped");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |-> out_x == SAT_MAX || out_x == SAT_MIN
      || out_y == SAT_MAX || out_y == SAT_MIN
      || out_z == SAT_MAX || out_z == SAT_MIN)
    else $error("clipped set with no coordinate on a rail");
endmodule

bind helmert_datum_shift_unit hds_checker u_hds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_x          (out_ch.out_x),
  .out_y          (out_ch.out_y),
  .out_z          (out_ch.out_z),
  .out_no_value   (out_ch.out_no_value),
  .clipped        (out_ch.clipped),
  .out_last_point (out_ch.out_last_point)
);
`default_nettype wire
